// File: design/can_bootloader_command_engine_core_defines.svh
// ----------------------------------------------------------------------------
// CAN bootloader command engine - assertion macros
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef CAN_BOOTLOADER_COMMAND_ENGINE_CORE_DEFINES_SVH
`define CAN_BOOTLOADER_COMMAND_ENGINE_CORE_DEFINES_SVH

// same-cycle implication
`define CBCE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CBCE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/cbce_pkg.sv
// ----------------------------------------------------------------------------
// CAN bootloader command engine - package
// Field widths, status/phase/register codes, response type, CRC byte step.
// ----------------------------------------------------------------------------
package cbce_pkg;

	localparam int ID_W     = 29;
	localparam int DLC_W    = 4;
	localparam int CNT20_W  = 20;
	localparam int CRC_W    = 32;
	localparam int STAT_W   = 3;
	localparam int PHASE_W  = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 29;
	localparam int NUM_CMDS = 5;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
	localparam logic [STAT_W-1:0] ST_CHECKSUM  = 3'd1;
	localparam logic [STAT_W-1:0] ST_BAD_CMD   = 3'd2;
	localparam logic [STAT_W-1:0] ST_BAD_STATE = 3'd3;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;
	localparam logic [STAT_W-1:0] ST_CRC       = 3'd5;

	// download phase
	localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd0;
	localparam logic [PHASE_W-1:0] PH_ACTIVE = 2'd1;
	localparam logic [PHASE_W-1:0] PH_ERROR  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WRITE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COMMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VERIFY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ABORT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE1  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE2  = 3'd6;

	// command lane order, also match priority
	localparam int CMD_START  = 0;
	localparam int CMD_WRITE  = 1;
	localparam int CMD_COMMIT = 2;
	localparam int CMD_VERIFY = 3;
	localparam int CMD_ABORT  = 4;

	localparam logic [ID_W-1:0]    RST_START_ID  = 29'd256;
	localparam logic [ID_W-1:0]    RST_WRITE_ID  = 29'd257;
	localparam logic [ID_W-1:0]    RST_COMMIT_ID = 29'd258;
	localparam logic [ID_W-1:0]    RST_VERIFY_ID = 29'd259;
	localparam logic [ID_W-1:0]    RST_ABORT_ID  = 29'd260;
	localparam logic [CNT20_W-1:0] RST_IMG_SIZE  = 20'd65536;

	localparam logic [CRC_W-1:0] CRC_PRESET = 32'hFFFF_FFFF;
	localparam logic [CRC_W-1:0] CRC_POLY   = 32'hEDB8_8320;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [PHASE_W-1:0] phase;
		logic               target_slot;
		logic               active_slot;
		logic [1:0]         valid_marks;
		logic [CNT20_W-1:0] byte_total;
		logic [CNT20_W-1:0] block_total;
		logic [CRC_W-1:0]   crc_value;
	} resp_t;

	typedef struct packed {
		logic busy;
		logic done;
	} crc_stat_t;

	// reflected CRC-32, one byte
	function automatic logic [CRC_W-1:0] cbce_crc_byte(input logic [CRC_W-1:0] c_in,
		input logic [7:0] b);
		logic [CRC_W-1:0] c;
		c = c_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// File: design/cbce_ifs.sv
// ----------------------------------------------------------------------------
// CAN bootloader command engine - channel interfaces
// Frame input, response output and register write channels.
// ----------------------------------------------------------------------------
interface cbce_frame_if import cbce_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [ID_W-1:0] can_id;
	logic [DLC_W-1:0] dlc;
	logic [7:0]      len_byte;
	logic [7:0]      pay0;
	logic [7:0]      pay1;
	logic [7:0]      pay2;
	logic [7:0]      pay3;
	logic [7:0]      pay4;
	logic [7:0]      pay5;
	logic [7:0]      check_byte;

	modport source (output valid, can_id, dlc, len_byte, pay0, pay1, pay2, pay3, pay4,
		pay5, check_byte, input ready);
	modport sink (input valid, can_id, dlc, len_byte, pay0, pay1, pay2, pay3, pay4,
		pay5, check_byte, output ready);
endinterface

interface cbce_resp_if import cbce_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [STAT_W-1:0]  status;
	logic [PHASE_W-1:0] phase;
	logic               target_slot;
	logic               active_slot;
	logic [1:0]         valid_marks;
	logic [CNT20_W-1:0] byte_total;
	logic [CNT20_W-1:0] block_total;
	logic [CRC_W-1:0]   crc_value;

	modport source (output valid, status, phase, target_slot, active_slot, valid_marks,
		byte_total, block_total, crc_value, input ready);
	modport sink (input valid, status, phase, target_slot, active_slot, valid_marks,
		byte_total, block_total, crc_value, output ready);
endinterface

interface cbce_cfg_if import cbce_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: design/cbce_id_lane.sv
// ----------------------------------------------------------------------------
// CAN bootloader command engine - identifier lane
// Compares the frame identifier against one command identifier, registered.
// ----------------------------------------------------------------------------
module cbce_id_lane import cbce_pkg::*; (
	input  logic            clk,
	input  logic            load,
	input  logic [ID_W-1:0] can_id,
	input  logic [ID_W-1:0] cmd_id,
	output logic            hit_s1
);

	always_ff @(posedge clk) begin
		if (load) begin
			hit_s1 <= (can_id == cmd_id);
		end
	end

endmodule

// File: design/cbce_crc_unit.sv
// ----------------------------------------------------------------------------
// CAN bootloader command engine - CRC unit
// Byte-serial reflected CRC-32 over the first cnt payload bytes.
// ----------------------------------------------------------------------------
module cbce_crc_unit import cbce_pkg::*; #(
	parameter int MAX_PAYLOAD = 6
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [$clog2(MAX_PAYLOAD+1)-1:0] cnt,
	input  logic [CRC_W-1:0]                crc_in,
	input  logic [MAX_PAYLOAD-1:0][7:0]     bytes,
	output logic [CRC_W-1:0]                crc_out,
	output crc_stat_t                       stat
);

	localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
	localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	logic             busy_q;
	logic             done_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] rem_q;
	logic [CRC_W-1:0] crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			idx_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
				rem_q  <= cnt;
			end else if (busy_q) begin
				idx_q <= idx_q + IDX_W'(1);
				rem_q <= rem_q - CNT_W'(1);
				if (rem_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			crc_q <= crc_in;
		end else if (busy_q) begin
			crc_q <= cbce_crc_byte(crc_q, bytes[idx_q]);
		end
	end

	assign crc_out   = crc_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// File: design/can_bootloader_command_engine_core.sv
// ----------------------------------------------------------------------------
// CAN bootloader command engine - top level
// Checks one received CAN frame per word, decodes its command and keeps
// the download state, counts, running CRC-32 and image marks.
//
//   channel | dir | handshake    | carries
//   --------+-----+--------------+-------------------------------------------
//   frame   | in  | valid/ready  | can_id, dlc, len_byte, pay0..5, check_byte
//   resp    | out | valid/ready  | status and state snapshot
//   cfg     | in  | valid/ready  | register index, write data
//
// A frame word passes capture, decode and response load in turn; a good
// write block adds a pass of the byte-serial CRC unit over its payload
// bytes between decode and response load.
// frame.ready is high only while idle; a waiting response register does
// not block acceptance, only the final load of the next response.
// Reset clears control and download state and loads register defaults.
// cfg.ready is always high.
// ----------------------------------------------------------------------------
module can_bootloader_command_engine_core import cbce_pkg::*; #(
	parameter int MAX_PAYLOAD = 6
) (
	input  logic       clk,
	input  logic       arst_n,
	cbce_frame_if.sink  frame,
	cbce_resp_if.source resp,
	cbce_cfg_if.sink    cfg
);

	`include "can_bootloader_command_engine_core_defines.svh"

	// payload storage never below four bytes: commit reads pay0..pay3
	localparam int PAY_N = (MAX_PAYLOAD < 4) ? 4 : MAX_PAYLOAD;
	localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

	// sequencer states
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DEC  = 2'd1;
	localparam logic [1:0] S_CRC  = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0] state_q;

	// configuration
	logic [ID_W-1:0]    cmd_id_q [NUM_CMDS];
	logic [CNT20_W-1:0] cap_q    [2];

	// download state
	logic [PHASE_W-1:0] phase_q;
	logic               slot_q;
	logic               active_q;
	logic [1:0]         valid_q;
	logic [CNT20_W-1:0] bytes_q;
	logic [CNT20_W-1:0] blocks_q;
	logic [CRC_W-1:0]   crc_q;
	logic [STAT_W-1:0]  status_q;

	// captured frame
	logic [7:0] len_s1;
	logic [7:0] chk_s1;
	logic [7:0] pay_s1 [PAY_N];
	logic [7:0] in_bytes [7];
	logic [NUM_CMDS-1:0] hit_s1;

	// response register
	resp_t resp_q;
	logic  out_valid_q;

	logic frame_acc;
	logic load_out;

	assign frame_acc   = frame.valid && frame.ready;
	assign frame.ready = (state_q == S_IDLE);
	assign cfg.ready   = 1'b1;
	assign load_out    = (state_q == S_DONE) && (!out_valid_q || resp.ready);

	// ---------------------------------------------------------------------
	// register writes
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_id_q[CMD_START]  <= RST_START_ID;
			cmd_id_q[CMD_WRITE]  <= RST_WRITE_ID;
			cmd_id_q[CMD_COMMIT] <= RST_COMMIT_ID;
			cmd_id_q[CMD_VERIFY] <= RST_VERIFY_ID;
			cmd_id_q[CMD_ABORT]  <= RST_ABORT_ID;
			cap_q[0]             <= RST_IMG_SIZE;
			cap_q[1]             <= RST_IMG_SIZE;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index) inside
				CFG_START, CFG_WRITE, CFG_COMMIT, CFG_VERIFY, CFG_ABORT: begin
					cmd_id_q[cfg.index] <= cfg.data;
				end
				CFG_SIZE1: cap_q[0] <= cfg.data[CNT20_W-1:0];
				CFG_SIZE2: cap_q[1] <= cfg.data[CNT20_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// capture: frame bytes, length and check byte per dlc
	// ---------------------------------------------------------------------
	assign in_bytes[0] = frame.pay0;
	assign in_bytes[1] = frame.pay1;
	assign in_bytes[2] = frame.pay2;
	assign in_bytes[3] = frame.pay3;
	assign in_bytes[4] = frame.pay4;
	assign in_bytes[5] = frame.pay5;
	assign in_bytes[6] = frame.check_byte;	// payload byte six when 7 allowed

	always_ff @(posedge clk) begin
		if (frame_acc) begin
			len_s1 <= (frame.dlc != '0) ? frame.len_byte : 8'd0;
			chk_s1 <= (frame.dlc > DLC_W'(7)) ? frame.check_byte : 8'd0;
			for (int i = 0; i < PAY_N; i++) begin
				pay_s1[i] <= in_bytes[i];
			end
		end
	end

	// identifier lanes, one per command
	for (genvar g = 0; g < NUM_CMDS; g++) begin : g_lane
		cbce_id_lane u_lane (
			.clk    (clk),
			.load   (frame_acc),
			.can_id (frame.can_id),
			.cmd_id (cmd_id_q[g]),
			.hit_s1 (hit_s1[g])
		);
	end

	// ---------------------------------------------------------------------
	// decode: length, checksum, merge of lane hits (first match wins)
	// ---------------------------------------------------------------------
	logic                   len_ok;
	logic [7:0]             sum;
	logic [CNT20_W:0]       bytes_sum;
	logic [CNT20_W-1:0]     cap_sel;
	logic [CRC_W-1:0]       want;
	logic [CRC_W-1:0]       crc_fin;
	logic [STAT_W-1:0]      n_status;
	logic [PHASE_W-1:0]     n_phase;
	logic                   n_slot;
	logic                   n_active;
	logic [1:0]             n_valid;
	logic [CNT20_W-1:0]     n_bytes;
	logic [CNT20_W-1:0]     n_blocks;
	logic [CRC_W-1:0]       n_crc;
	logic                   crc_go;

	always_comb begin
		len_ok = (len_s1 <= 8'(MAX_PAYLOAD));
		sum    = len_s1;
		for (int i = 0; i < MAX_PAYLOAD; i++) begin
			if (8'(i) < len_s1) begin
				sum = sum ^ pay_s1[i];
			end
		end
		bytes_sum = {1'b0, bytes_q} + (CNT20_W+1)'(len_s1);
		cap_sel   = slot_q ? cap_q[1] : cap_q[0];
		want      = (len_s1 >= 8'd4) ? {pay_s1[3], pay_s1[2], pay_s1[1], pay_s1[0]}
			: '0;
		crc_fin   = ~crc_q;

		n_status = status_q;
		n_phase  = phase_q;
		n_slot   = slot_q;
		n_active = active_q;
		n_valid  = valid_q;
		n_bytes  = bytes_q;
		n_blocks = blocks_q;
		n_crc    = crc_q;
		crc_go   = 1'b0;

		if (!len_ok) begin
			n_status = ST_BAD_CMD;
		end else if (sum != chk_s1) begin
			n_status = ST_CHECKSUM;
		end else if (hit_s1[CMD_START]) begin
			if (phase_q == PH_ACTIVE) begin
				n_status = ST_BAD_STATE;
			end else if (len_s1 == 8'd0 || pay_s1[0] > 8'd1) begin
				n_status = ST_BAD_CMD;
			end else begin
				n_slot   = pay_s1[0][0];
				n_phase  = PH_ACTIVE;
				n_bytes  = '0;
				n_blocks = '0;
				n_crc    = CRC_PRESET;
				n_status = ST_OK;
			end
		end else if (hit_s1[CMD_WRITE]) begin
			if (phase_q != PH_ACTIVE) begin
				n_status = ST_BAD_STATE;
			end else if (len_s1 == 8'd0) begin
				n_status = ST_BAD_CMD;
			end else if (bytes_sum > {1'b0, cap_sel}) begin
				n_phase  = PH_ERROR;
				n_status = ST_FULL;
			end else begin
				// CRC itself is folded in by the CRC unit
				crc_go   = 1'b1;
				n_bytes  = bytes_sum[CNT20_W-1:0];
				n_blocks = blocks_q + CNT20_W'(1);
				n_status = ST_OK;
			end
		end else if (hit_s1[CMD_COMMIT]) begin
			if (phase_q != PH_ACTIVE) begin
				n_status = ST_BAD_STATE;
			end else begin
				n_crc = crc_fin;
				if (want != crc_fin) begin
					n_phase  = PH_ERROR;
					n_status = ST_CRC;
				end else begin
					n_valid  = valid_q | (slot_q ? 2'b10 : 2'b01);
					n_active = slot_q;
					n_phase  = PH_IDLE;
					n_status = ST_OK;
				end
			end
		end else if (hit_s1[CMD_VERIFY]) begin
			if (len_s1 == 8'd0) begin
				n_status = ST_BAD_CMD;
			end else if ((valid_q & ((pay_s1[0] == 8'd0) ? 2'b01 : 2'b10)) != 2'b00) begin
				n_status = ST_OK;
			end else begin
				n_status = ST_CRC;
			end
		end else if (hit_s1[CMD_ABORT]) begin
			n_phase  = PH_IDLE;
			n_bytes  = '0;
			n_blocks = '0;
			n_crc    = CRC_PRESET;
			n_status = ST_OK;
		end else begin
			n_status = ST_BAD_CMD;
		end
	end

	// ---------------------------------------------------------------------
	// CRC unit
	// ---------------------------------------------------------------------
	logic [MAX_PAYLOAD-1:0][7:0] crc_bytes;
	logic [CRC_W-1:0]            crc_res;
	crc_stat_t                   crc_stat;

	always_comb begin
		for (int i = 0; i < MAX_PAYLOAD; i++) begin
			crc_bytes[i] = pay_s1[i];
		end
	end

	cbce_crc_unit #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_crc (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   ((state_q == S_DEC) && crc_go),
		.cnt     (len_s1[CNT_W-1:0]),
		.crc_in  (crc_q),
		.bytes   (crc_bytes),
		.crc_out (crc_res),
		.stat    (crc_stat)
	);

	// ---------------------------------------------------------------------
	// sequencer and download state
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_IDLE;
			slot_q      <= 1'b0;
			active_q    <= 1'b0;
			valid_q     <= 2'b00;
			bytes_q     <= '0;
			blocks_q    <= '0;
			crc_q       <= CRC_PRESET;
			status_q    <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			// a new load wins over the drain of the old word
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (resp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (frame_acc) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					phase_q  <= n_phase;
					slot_q   <= n_slot;
					active_q <= n_active;
					valid_q  <= n_valid;
					bytes_q  <= n_bytes;
					blocks_q <= n_blocks;
					crc_q    <= n_crc;
					status_q <= n_status;
					state_q  <= crc_go ? S_CRC : S_DONE;
				end
				S_CRC: begin
					if (crc_stat.done) begin
						crc_q   <= crc_res;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// response snapshot
	always_ff @(posedge clk) begin
		if (load_out) begin
			resp_q.status      <= status_q;
			resp_q.phase       <= phase_q;
			resp_q.target_slot <= slot_q;
			resp_q.active_slot <= active_q;
			resp_q.valid_marks <= valid_q;
			resp_q.byte_total  <= bytes_q;
			resp_q.block_total <= blocks_q;
			resp_q.crc_value   <= crc_q;
		end
	end

	assign resp.valid       = out_valid_q;
	assign resp.status      = resp_q.status;
	assign resp.phase       = resp_q.phase;
	assign resp.target_slot = resp_q.target_slot;
	assign resp.active_slot = resp_q.active_slot;
	assign resp.valid_marks = resp_q.valid_marks;
	assign resp.byte_total  = resp_q.byte_total;
	assign resp.block_total = resp_q.block_total;
	assign resp.crc_value   = resp_q.crc_value;

	// ---------------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------------
	`CBCE_ASSERT_NXT(a_acc_to_dec, frame_acc, state_q == S_DEC, "accepted word not decoded")
	`CBCE_ASSERT_IMP(a_blk_src, !$stable(blocks_q), $past(state_q) == S_DEC, "block count moved outside decode")
	`CBCE_ASSERT_IMP(a_crc_done, crc_stat.done, state_q == S_CRC, "CRC result with no write pending")

endmodule
